### hw/rtl/dsbt_pkg.sv
// shared types, constants and codes for the dhcp snooping binding table
package dsbt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int STEP_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TABLE_DEPTH - 1);

    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_LOOKUP = 3'd1;
    localparam logic [2:0] FUNC_DELETE = 3'd2;
    localparam logic [2:0] FUNC_CLEAR  = 3'd3;
    localparam logic [2:0] FUNC_AGE    = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_VLAN  = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    localparam logic [11:0] VLAN_MIN   = 12'd1;
    localparam logic [11:0] VLAN_LIMIT = 12'd4095;

    typedef struct packed {
        logic [2:0]  func;
        logic [47:0] client_mac;
        logic [31:0] client_ip;
        logic [31:0] lease_seconds;
        logic [31:0] expiry_second;
        logic [11:0] vlan;
        logic [31:0] now_second;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [47:0] found_mac;
        logic [31:0] found_lease;
        logic [31:0] found_expiry;
        logic [6:0]  removed_count;
    } rsp_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
        logic [31:0] lease;
        logic [31:0] expiry;
        logic [11:0] vlan;
    } binding_t;

    typedef struct packed {
        logic     valid;
        binding_t info;
    } entry_t;

    // first-match data travelling toward the head
    typedef struct packed {
        logic        found;
        logic [47:0] mac;
        logic [31:0] lease;
        logic [31:0] expiry;
    } carry_t;

    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_INSERT  = 2'd1,
        CELL_KILL    = 2'd2,
        CELL_COMPACT = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        KILL_FIRST   = 2'd0,
        KILL_EXPIRED = 2'd1,
        KILL_ALL     = 2'd2
    } kill_sel_t;

    typedef struct packed {
        cell_op_t    op;
        kill_sel_t   kill_sel;
        logic [31:0] ip;
        logic [11:0] vlan;
        logic [31:0] now;
    } cell_ctrl_t;

endpackage

### hw/rtl/dsbt_cell.sv
// one table slot: holds a binding and trades data with its two neighbors
module dsbt_cell
    import dsbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     left_ent,
    input  entry_t     right_ent,
    output entry_t     ent,
    input  logic       seen_in,
    output logic       seen_out,
    input  carry_t     carry_in,
    output carry_t     carry_out,
    input  logic       kill_in,
    output logic       kill_out
);

    logic     valid_reg, valid_next;
    binding_t info_reg, info_next;
    logic     kill_reg, kill_next;
    logic     seen_reg;
    carry_t   carry_reg, carry_next;
    logic     match;
    logic     cond;

    assign match = valid_reg && (info_reg.ip == ctrl.ip) && (info_reg.vlan == ctrl.vlan);

    always_comb
    begin
        case (ctrl.kill_sel)
            KILL_FIRST:   cond = match && !seen_reg;
            KILL_EXPIRED: cond = (ctrl.now >= info_reg.expiry);
            default:      cond = 1'b1;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        info_next  = info_reg;
        kill_next  = kill_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                valid_next = left_ent.valid;
                info_next  = left_ent.info;
            end
            CELL_KILL:
            begin
                valid_next = valid_reg && !cond;
                kill_next  = valid_reg && cond;
            end
            CELL_COMPACT:
            begin
                kill_next = kill_in;
                // a hole pulls its right neighbor in, a slot after a hole hands over
                if (!valid_reg && right_ent.valid)
                begin
                    valid_next = 1'b1;
                    info_next  = right_ent.info;
                end
                else if (valid_reg && !left_ent.valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_comb
    begin
        if (match)
        begin
            carry_next.found  = 1'b1;
            carry_next.mac    = info_reg.mac;
            carry_next.lease  = info_reg.lease;
            carry_next.expiry = info_reg.expiry;
        end
        else
        begin
            carry_next = carry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            kill_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            kill_reg  <= kill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg  <= info_next;
        seen_reg  <= seen_in;
        carry_reg <= carry_next;
    end

    assign ent.valid = valid_reg;
    assign ent.info  = info_reg;
    assign seen_out  = seen_reg || match;
    assign carry_out = carry_reg;
    assign kill_out  = kill_reg;

endmodule

### hw/rtl/dhcp_snooping_binding_table.sv
// top level: sequencer and the row of binding cells
//
// channel  direction  ports              beat taken when
// req      in         start, busy, req   start high and busy low at a clock edge
// res      out        done, res          done high for one cycle, always taken
//
// insert and unused codes finish in the exec state; clear and age run one compaction sweep;
// lookup runs one search; delete runs a search and, on a hit, a sweep. search and compaction
// waves move one cell per clock along the row, so the row length sets their run time.
// busy is high from acceptance until done
// rises; a new beat can be taken in the done cycle. reset empties the table at once.
// the receiver cannot stall, so results never wait.
module dhcp_snooping_binding_table
    import dsbt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t res
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_FIND   = 5'b01000,
        S_SWEEP  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  acc_reg, acc_next;
    logic              done_reg, done_next;
    rsp_t              res_reg, res_next;
    req_t              cmd_reg, cmd_next;
    cell_op_t          op;
    kill_sel_t         kill_sel;
    cell_ctrl_t        ctrl;
    logic              accept;
    logic              bad_vlan;
    logic              full;

    entry_t                 ent_w   [TABLE_DEPTH];
    entry_t                 left_w  [TABLE_DEPTH];
    entry_t                 right_w [TABLE_DEPTH];
    logic                   seen_w  [TABLE_DEPTH];
    logic                   seen_in [TABLE_DEPTH];
    carry_t                 carry_w [TABLE_DEPTH];
    carry_t                 carry_in[TABLE_DEPTH];
    logic                   kill_w  [TABLE_DEPTH];
    logic                   kill_in [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH:0]   fill_probe;
    entry_t                 head_ent;
    entry_t                 empty_ent;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // new binding enters at the head; its valid bit also stops the head from handing over
    assign head_ent.valid       = 1'b1;
    assign head_ent.info.mac    = cmd_reg.client_mac;
    assign head_ent.info.ip     = cmd_reg.client_ip;
    assign head_ent.info.lease  = cmd_reg.lease_seconds;
    assign head_ent.info.expiry = cmd_reg.expiry_second;
    assign head_ent.info.vlan   = cmd_reg.vlan;
    assign empty_ent            = '0;

    assign ctrl.op       = op;
    assign ctrl.kill_sel = kill_sel;
    assign ctrl.ip       = cmd_reg.client_ip;
    assign ctrl.vlan     = cmd_reg.vlan;
    assign ctrl.now      = cmd_reg.now_second;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_row
        if (i == 0)
        begin : g_head
            assign left_w[i]  = head_ent;
            assign seen_in[i] = 1'b0;
        end
        else
        begin : g_mid_l
            assign left_w[i]  = ent_w[i-1];
            assign seen_in[i] = seen_w[i-1];
        end
        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign right_w[i]  = empty_ent;
            assign carry_in[i] = '0;
            assign kill_in[i]  = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_w[i]  = ent_w[i+1];
            assign carry_in[i] = carry_w[i+1];
            assign kill_in[i]  = kill_w[i+1];
        end
        assign valid_vec[i] = ent_w[i].valid;

        dsbt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left_ent  (left_w[i]),
            .right_ent (right_w[i]),
            .ent       (ent_w[i]),
            .seen_in   (seen_in[i]),
            .seen_out  (seen_w[i]),
            .carry_in  (carry_in[i]),
            .carry_out (carry_w[i]),
            .kill_in   (kill_in[i]),
            .kill_out  (kill_w[i])
        );
    end

    // the table stays packed toward the head, so the tail slot tells full
    assign full     = valid_vec[TABLE_DEPTH-1];
    assign bad_vlan = (cmd_reg.vlan < VLAN_MIN) || (cmd_reg.vlan >= VLAN_LIMIT);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        cmd_next   = accept ? req : cmd_reg;
        op         = CELL_HOLD;
        kill_sel   = KILL_ALL;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                step_next = '0;
                acc_next  = '0;
                case (cmd_reg.func)
                    FUNC_INSERT:
                    begin
                        res_next = '0;
                        if (bad_vlan)
                        begin
                            res_next.status = STATUS_BAD_VLAN;
                        end
                        else if (full)
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            op              = CELL_INSERT;
                            res_next.status = STATUS_OK;
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    FUNC_LOOKUP, FUNC_DELETE:
                    begin
                        state_next = S_SEARCH;
                    end
                    FUNC_CLEAR:
                    begin
                        op         = CELL_KILL;
                        kill_sel   = KILL_ALL;
                        state_next = S_SWEEP;
                    end
                    FUNC_AGE:
                    begin
                        op         = CELL_KILL;
                        kill_sel   = KILL_EXPIRED;
                        state_next = S_SWEEP;
                    end
                    default:
                    begin
                        res_next   = '0;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SEARCH:
            begin
                // carry and seen waves settle over one full row length
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                step_next = '0;
                acc_next  = '0;
                res_next  = '0;
                if (!carry_w[0].found)
                begin
                    res_next.status = STATUS_NOT_FOUND;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (cmd_reg.func == FUNC_LOOKUP)
                begin
                    res_next.status       = STATUS_OK;
                    res_next.hit          = 1'b1;
                    res_next.found_mac    = carry_w[0].mac;
                    res_next.found_lease  = carry_w[0].lease;
                    res_next.found_expiry = carry_w[0].expiry;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    op         = CELL_KILL;
                    kill_sel   = KILL_FIRST;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                // compact the row while the kill marks shift out at the head
                op        = CELL_COMPACT;
                acc_next  = acc_reg + CNT_W'(kill_w[0]);
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    res_next               = '0;
                    res_next.status        = STATUS_OK;
                    res_next.hit           = (cmd_reg.func == FUNC_DELETE);
                    res_next.removed_count = 7'(acc_next);
                    done_next              = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        cmd_reg <= cmd_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

    assign fill_probe = {1'b0, valid_vec} + (TABLE_DEPTH + 1)'(1);

    // between commands the valid slots form one run from the head
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> $onehot(fill_probe))
        else $error("binding table not packed toward the head");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a command in flight");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results for one command");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted command not taken up");

endmodule

### tb/sv/tb.sv
// self-checking testbench for the dhcp snooping binding table: directed and random operations
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsbt_pkg::*;

    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
    localparam int STALL_LIMIT   = 8 * (2 * TABLE_DEPTH + 3) + 64;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t res;

    // predicted table contents, newest binding at index 0
    binding_t bindings[$];
    rsp_t pending_rsp[$];
    logic [31:0] ip_pool [8];
    logic [11:0] vlan_pool [4];
    int sender_idle_pct = 0;
    int mismatch_count  = 0;
    int stall_cycles    = 0;

    always #2 clk = ~clk;

    dhcp_snooping_binding_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    function automatic rsp_t predict_binding(input req_t r);
        rsp_t o;
        binding_t b;
        int hit_at;
        int k;
        o = '0;
        hit_at = -1;
        if (r.func == FUNC_LOOKUP || r.func == FUNC_DELETE)
        begin
            for (k = 0; k < bindings.size(); k++)
            begin
                if (hit_at < 0 && bindings[k].ip == r.client_ip && bindings[k].vlan == r.vlan)
                    hit_at = k;
            end
        end
        case (r.func)
            FUNC_INSERT:
            begin
                if (r.vlan < VLAN_MIN || r.vlan >= VLAN_LIMIT)
                    o.status = STATUS_BAD_VLAN;
                else if (bindings.size() >= TABLE_DEPTH)
                    o.status = STATUS_FULL;
                else
                begin
                    b.mac    = r.client_mac;
                    b.ip     = r.client_ip;
                    b.lease  = r.lease_seconds;
                    b.expiry = r.expiry_second;
                    b.vlan   = r.vlan;
                    bindings.push_front(b);
                end
            end
            FUNC_LOOKUP, FUNC_DELETE:
            begin
                if (hit_at < 0)
                    o.status = STATUS_NOT_FOUND;
                else
                begin
                    o.hit = 1'b1;
                    if (r.func == FUNC_LOOKUP)
                    begin
                        o.found_mac    = bindings[hit_at].mac;
                        o.found_lease  = bindings[hit_at].lease;
                        o.found_expiry = bindings[hit_at].expiry;
                    end
                    else
                    begin
                        bindings.delete(hit_at);
                        o.removed_count = 7'd1;
                    end
                end
            end
            FUNC_CLEAR:
            begin
                o.removed_count = 7'(bindings.size());
                bindings.delete();
            end
            FUNC_AGE:
            begin
                k = 0;
                while (k < bindings.size())
                begin
                    if (r.now_second >= bindings[k].expiry)
                    begin
                        bindings.delete(k);
                        o.removed_count = o.removed_count + 7'd1;
                    end
                    else
                        k++;
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic req_t make_req(input logic [2:0] op, input logic [47:0] mac,
                                      input logic [31:0] ip, input logic [31:0] lease,
                                      input logic [31:0] expiry, input logic [11:0] vlan,
                                      input logic [31:0] now);
        req_t r;
        r.func          = op;
        r.client_mac    = mac;
        r.client_ip     = ip;
        r.lease_seconds = lease;
        r.expiry_second = expiry;
        r.vlan          = vlan;
        r.now_second    = now;
        return r;
    endfunction

    // keys mostly from small pools so lookups and deletes hit, times in a narrow window
    function automatic req_t rand_req();
        req_t r;
        int sel;
        r.client_mac    = {16'($urandom()), 32'($urandom())};
        r.client_ip     = ($urandom_range(9) < 9) ? ip_pool[$urandom_range(7)] : 32'($urandom());
        r.lease_seconds = $urandom();
        r.expiry_second = ($urandom_range(4) < 4) ? 32'($urandom_range(1000, 2000))
                                                  : 32'($urandom());
        r.now_second    = ($urandom_range(4) < 4) ? 32'($urandom_range(900, 2100))
                                                  : 32'($urandom());
        sel = $urandom_range(19);
        if (sel < 17)
            r.vlan = vlan_pool[$urandom_range(3)];
        else if (sel == 17)
            r.vlan = '0;
        else if (sel == 18)
            r.vlan = VLAN_LIMIT;
        else
            r.vlan = 12'($urandom_range(4095));
        sel = $urandom_range(99);
        if (sel < 40)
            r.func = FUNC_INSERT;
        else if (sel < 65)
            r.func = FUNC_LOOKUP;
        else if (sel < 83)
            r.func = FUNC_DELETE;
        else if (sel < 91)
            r.func = FUNC_AGE;
        else if (sel < 93)
            r.func = FUNC_CLEAR;
        else
            r.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        return r;
    endfunction

    // returns at the edge that takes the beat; start stays high for a back-to-back beat
    task automatic send_req(input req_t item);
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(1, ($urandom_range(3) == 0) ? 2 * TABLE_DEPTH + 4 : 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_rsp.push_back(predict_binding(item));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_insert_and_lookup();
        sender_idle_pct = 0;
        send_req(make_req(FUNC_INSERT, '1, '1, '1, '1, VLAN_LIMIT - 12'd1, '0));
        send_req(make_req(FUNC_INSERT, '0, '0, '0, '0, VLAN_MIN, '0));
        send_req(make_req(FUNC_INSERT, 48'h0123_4567_89ab, '1, 32'd10, 32'd20, '0, '0));
        send_req(make_req(FUNC_INSERT, 48'h0123_4567_89ab, '1, 32'd10, 32'd20, VLAN_LIMIT, '0));
        // duplicate key, newer copy must win
        send_req(make_req(FUNC_INSERT, 48'ha5a5_5a5a_a5a5, '0, 32'd100, 32'd200, VLAN_MIN, '0));
        send_req(make_req(FUNC_LOOKUP, '0, '0, '0, '0, VLAN_MIN, '0));
        send_req(make_req(FUNC_LOOKUP, '0, '1, '0, '0, VLAN_LIMIT - 12'd1, '0));
        send_req(make_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, '0));
        send_req(make_req(FUNC_LOOKUP, '0, '1, '0, '0, VLAN_LIMIT, '0));
        send_req(make_req(FUNC_LOOKUP, '0, '0, '0, '0, 12'd2, '0));
        drain_results();
    endtask

    task automatic test_delete_newest();
        sender_idle_pct = 0;
        send_req(make_req(FUNC_DELETE, '0, '0, '0, '0, VLAN_MIN, '0));
        send_req(make_req(FUNC_LOOKUP, '0, '0, '0, '0, VLAN_MIN, '0));
        send_req(make_req(FUNC_DELETE, '0, 32'd5, '0, '0, 12'd5, '0));
        drain_results();
    endtask

    task automatic test_unused_codes();
        sender_idle_pct = 0;
        for (int c = FUNC_SPARE_FIRST; c <= FUNC_SPARE_LAST; c++)
            send_req(make_req(3'(c), '1, '1, '1, '1, '1, '1));
        drain_results();
    endtask

    task automatic test_age_and_clear();
        sender_idle_pct = 0;
        // expiry equal to now counts as expired
        send_req(make_req(FUNC_AGE, '0, '0, '0, '0, '0, '0));
        send_req(make_req(FUNC_AGE, '0, '0, '0, '0, '0, '0));
        send_req(make_req(FUNC_AGE, '0, '0, '0, '0, '0, '1));
        send_req(make_req(FUNC_CLEAR, '0, '0, '0, '0, '0, '0));
        send_req(make_req(FUNC_INSERT, 48'h1, 32'h0a00_0001, 32'd60, 32'd500, 12'd7, '0));
        send_req(make_req(FUNC_INSERT, 48'h2, 32'h0a00_0002, 32'd60, 32'd500, 12'd7, '0));
        send_req(make_req(FUNC_CLEAR, '0, '0, '0, '0, '0, '0));
        drain_results();
    endtask

    task automatic test_table_full();
        req_t r;
        sender_idle_pct = 0;
        repeat (TABLE_DEPTH)
        begin
            r = rand_req();
            r.func = FUNC_INSERT;
            r.vlan = vlan_pool[$urandom_range(3)];
            send_req(r);
        end
        r = rand_req();
        r.func = FUNC_INSERT;
        r.vlan = vlan_pool[0];
        send_req(r);
        // bad vlan is reported ahead of full
        r.vlan = VLAN_LIMIT;
        send_req(r);
        r.vlan = '0;
        send_req(r);
        r.func      = FUNC_LOOKUP;
        r.client_ip = bindings[$].ip;
        r.vlan      = bindings[$].vlan;
        send_req(r);
        r.func = FUNC_DELETE;
        send_req(r);
        r = rand_req();
        r.func = FUNC_INSERT;
        r.vlan = vlan_pool[1];
        send_req(r);
        r.func       = FUNC_AGE;
        r.now_second = 32'd1500;
        send_req(r);
        r.now_second = '1;
        send_req(r);
        drain_results();
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct);
        sender_idle_pct = idle_pct;
        repeat (items)
        begin
            send_req(rand_req());
            if ($urandom_range(99) < 2)
                drain_results();
        end
        drain_results();
    endtask

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result beat with nothing pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (res.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res.status);
                    mismatch_count++;
                end
                if (res.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, res.hit);
                    mismatch_count++;
                end
                if (res.found_mac !== want.found_mac)
                begin
                    $error("found_mac: expected %h, got %h", want.found_mac, res.found_mac);
                    mismatch_count++;
                end
                if (res.found_lease !== want.found_lease)
                begin
                    $error("found_lease: expected %h, got %h", want.found_lease, res.found_lease);
                    mismatch_count++;
                end
                if (res.found_expiry !== want.found_expiry)
                begin
                    $error("found_expiry: expected %h, got %h",
                           want.found_expiry, res.found_expiry);
                    mismatch_count++;
                end
                if (res.removed_count !== want.removed_count)
                begin
                    $error("removed_count: expected %0d, got %0d",
                           want.removed_count, res.removed_count);
                    mismatch_count++;
                end
            end
        end
    end

    // no beat in either direction for too long means the block is hung
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        foreach (ip_pool[i])
            ip_pool[i] = $urandom();
        vlan_pool[0] = VLAN_MIN;
        vlan_pool[1] = VLAN_LIMIT - 12'd1;
        vlan_pool[2] = 12'($urandom_range(2, 4093));
        vlan_pool[3] = 12'($urandom_range(2, 4093));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_insert_and_lookup();
        test_delete_newest();
        test_unused_codes();
        test_age_and_clear();
        test_table_full();
        test_random_traffic(290, 0);
        test_random_traffic(290, 65);
        test_random_traffic(290, 33);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
